FILE: design/lpfr_pkg.sv
// Shared types and constants for the length-prefixed frame receiver.
// Holds the parse phase, the byte role codes and the result record.
// No dependencies.
package lpfr_pkg;

	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned KIND_W  = 3;
	localparam int unsigned CHECK_W = 16;
	localparam int unsigned TDATA_W = 48;

	// Which byte of the frame is expected next
	typedef enum logic [2:0] {
		PH_TYPE   = 3'd0,
		PH_SIZE   = 3'd1,
		PH_DATA   = 3'd2,
		PH_CHK_HI = 3'd3,
		PH_CHK_LO = 3'd4
	} phase_t;

	// Role of a byte within its frame
	typedef enum logic [KIND_W-1:0] {
		KIND_TYPE   = 3'd0,
		KIND_SIZE   = 3'd1,
		KIND_DATA   = 3'd2,
		KIND_CHK_HI = 3'd3,
		KIND_CHK_LO = 3'd4
	} kind_t;

	// One tagged result beat
	typedef struct packed {
		logic [CHECK_W-1:0] frame_check;
		logic [BYTE_W-1:0]  frame_size;
		logic [BYTE_W-1:0]  frame_type;
		logic               frame_done;
		logic [BYTE_W-1:0]  payload_index;
		logic [BYTE_W-1:0]  byte_value;
		kind_t              field_kind;
	} result_t;

endpackage

FILE: design/lpfr_decode.sv
// Frame parse state and per-byte tagging logic.
// Holds phase, payload count, type, size and high check byte; updates them
// on each advancing byte. Depends on lpfr_pkg.
module lpfr_decode (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       advance,
	input  logic [lpfr_pkg::BYTE_W-1:0] rx_byte,
	output lpfr_pkg::result_t          result
);
	import lpfr_pkg::*;

	phase_t            phase_q, phase_d;
	logic [BYTE_W-1:0] count_q, count_d;
	logic [BYTE_W-1:0] type_q, type_d;
	logic [BYTE_W-1:0] size_q, size_d;
	logic [BYTE_W-1:0] chk_hi_q, chk_hi_d;
	logic [BYTE_W-1:0] count_inc;

	assign count_inc = count_q + 8'd1;

	// Tag the byte and work out the next parse state
	always_comb begin
		phase_d  = phase_q;
		count_d  = count_q;
		type_d   = type_q;
		size_d   = size_q;
		chk_hi_d = chk_hi_q;

		result               = '0;
		result.byte_value    = rx_byte;
		result.frame_type    = type_q;
		result.frame_size    = size_q;

		unique case (phase_q)
			PH_SIZE: begin
				result.field_kind = KIND_SIZE;
				result.frame_size = rx_byte;
				size_d            = rx_byte;
				count_d           = '0;
				// zero-length frame skips straight to the check bytes
				phase_d           = (rx_byte == '0) ? PH_CHK_HI : PH_DATA;
			end
			PH_DATA: begin
				result.field_kind    = KIND_DATA;
				result.payload_index = count_q;
				if (count_inc == size_q) begin
					count_d = '0;
					phase_d = PH_CHK_HI;
				end else begin
					count_d = count_inc;
				end
			end
			PH_CHK_HI: begin
				result.field_kind = KIND_CHK_HI;
				chk_hi_d          = rx_byte;
				phase_d           = PH_CHK_LO;
			end
			PH_CHK_LO: begin
				result.field_kind  = KIND_CHK_LO;
				result.frame_done  = 1'b1;
				result.frame_check = {chk_hi_q, rx_byte};
				phase_d            = PH_TYPE;
			end
			default: begin
				result.field_kind = KIND_TYPE;
				result.frame_type = rx_byte;
				result.frame_size = '0;
				type_d            = rx_byte;
				phase_d           = PH_SIZE;
			end
		endcase
	end

	// Advance parse state once per byte moved to the output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TYPE;
			count_q  <= '0;
			type_q   <= '0;
			size_q   <= '0;
			chk_hi_q <= '0;
		end else if (advance) begin
			phase_q  <= phase_d;
			count_q  <= count_d;
			type_q   <= type_d;
			size_q   <= size_d;
			chk_hi_q <= chk_hi_d;
		end
	end

endmodule

FILE: design/length_prefixed_frame_receiver_core.sv
// Length-prefixed frame receiver: top level with input and result registers.
// A frame is type, size, size payload bytes, then check high and check low.
// Every received beat on s_* produces one tagged beat on m_*.
// A beat accepted into the input register moves on to the result register,
// and so onto m_*, once that register is free or being taken.
// Throughput: one beat per cycle while m_tready is high; the input register
// and the result register are both refilled in the cycle the result is taken.
// The only loop is the parse state in lpfr_decode, one short update a byte.
// When m_tready is low the result holds, the input register still takes one
// more beat, and then s_tready drops until the result is taken.
// m_tuser carries the byte role: 0 type, 1 size, 2 payload, 3 check high,
// 4 check low. m_tlast marks the check low byte, which closes the frame.
// frame_check is zero on every beat that does not close a frame.
// Reset empties both registers and puts the parser back to expecting a
// type byte.
// Depends on lpfr_pkg and lpfr_decode.
module length_prefixed_frame_receiver_core (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [7:0]                   s_tdata,  // [7:0] rx_byte
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [lpfr_pkg::TDATA_W-1:0] m_tdata,  // [7:0] byte_value,
	                                               // [15:8] payload_index,
	                                               // [23:16] frame_type,
	                                               // [31:24] frame_size,
	                                               // [47:32] frame_check
	output logic [lpfr_pkg::KIND_W-1:0]  m_tuser,  // [2:0] field_kind
	output logic                         m_tlast   // frame_done
);
	import lpfr_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              out_valid_q;
	result_t           out_q;
	result_t           result;
	logic              advance;

	// Move the held byte on when the result register is free or being taken
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1 <= s_tdata;
		end
	end

	lpfr_decode u_decode (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.rx_byte (byte_s1),
		.result  (result)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.field_kind;
	assign m_tlast  = out_q.frame_done;
	assign m_tdata  = {out_q.frame_check, out_q.frame_size, out_q.frame_type,
	                   out_q.payload_index, out_q.byte_value};

`ifndef SYNTHESIS
	// Frame end is flagged only on the low check byte
	a_done_kind: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tlast == (out_q.field_kind == KIND_CHK_LO)))
		else $error("frame_done not tied to check low byte");

	// Check value stays zero away from the frame end
	a_check_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tlast) |-> (out_q.frame_check == '0))
		else $error("frame_check nonzero outside frame end");

	// Payload index is zero on every non-payload byte
	a_index_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (out_q.field_kind != KIND_DATA)) |-> (out_q.payload_index == '0))
		else $error("payload_index nonzero on non-payload byte");

	// A held input byte is not overwritten while the output stalls
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(byte_s1)))
		else $error("input register lost a byte");

	// A stalled result is not overwritten by a new byte
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !m_tready) |-> !advance)
		else $error("result register overwritten while stalled");
`endif

endmodule
